// ===== hdl/wf_pkg.sv =====
// wf_pkg: shared widths, register map, reset values and helpers for the
// 3x3 window filter. No dependencies; compiled before every other file.

package wf_pkg;

	// stream payload widths
	localparam int PIXEL_W      = 8;
	localparam int SUM_W        = 28;
	localparam int WEIGHT_W     = 16;
	localparam int PROD_W       = WEIGHT_W + PIXEL_W + 1;
	localparam int KERNEL_SIZE  = 3;

	// configuration register widths
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_W     = 16;
	localparam int ROWREG_W     = KERNEL_SIZE * WEIGHT_W;

	// row counters have headroom past the last row for drain pushes
	localparam int ROW_W        = HEIGHT_W + 2;

	// defaults
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int RESET_WIDTH   = 1024;
	localparam int RESET_HEIGHT  = 480;
	localparam logic [ROWREG_W-1:0] RESET_TOP = '0;
	localparam logic [ROWREG_W-1:0] RESET_MID = ROWREG_W'(4096);
	localparam logic [ROWREG_W-1:0] RESET_BOT = '0;

	// result queue
	localparam int FIFO_DEPTH   = 8;

	// APB port
	localparam int APB_AW       = 6;
	localparam int APB_DW       = 64;

	// register map, 8-byte stride
	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_TOP    = 3'd2,
		REG_MID    = 3'd3,
		REG_BOT    = 3'd4
	} reg_idx_t;

	// request kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	// one Q4.12 weight out of a packed kernel row, left column in the low bits
	function automatic logic signed [WEIGHT_W-1:0] weight_at(
		input logic [ROWREG_W-1:0] row_w,
		input int unsigned         col
	);
		return row_w[col*WEIGHT_W +: WEIGHT_W];
	endfunction

endpackage

// ===== hdl/wf_pixel_if.sv =====
// wf_pixel_if: valid/ready channel carrying pixel and drain requests.
// Depends on wf_pkg for the pixel width.

interface wf_pixel_if import wf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [PIXEL_W-1:0] pixel;

	modport source (output valid, output kind, output pixel, input ready);
	modport sink   (input valid, input kind, input pixel, output ready);
endinterface

// ===== hdl/wf_result_if.sv =====
// wf_result_if: valid/ready channel carrying filter results.
// Depends on wf_pkg for the sum width.

interface wf_result_if import wf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] sum_value;
	logic                    frame_last;

	modport source (output valid, output sum_value, output frame_last, input ready);
	modport sink   (input valid, input sum_value, input frame_last, output ready);
endinterface

// ===== hdl/window_filter_3x3.sv =====
// window_filter_3x3: streaming 3x3 zero-padded correlation, 8-bit pixels, Q4.12 weights.
// Throughput: one request per cycle while ready is high; a drain that must push two zero pixels
// holds ready low for its second push, since the line memory is read once per pushed pixel.
// A config write drops ready in the cycle after it. Reset: config returns to its defaults and
// a clearing pass zeroes all MAX_WIDTH line memory entries, during which no request is taken.
// Depends on wf_pkg, wf_pixel_if, wf_result_if.

module window_filter_3x3 import wf_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	wf_pixel_if.sink          pixels,
	wf_result_if.source       results
);

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int EW      = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_W) ?
	                         $clog2(MAX_WIDTH + 1) : WIDTH_REG_W;
	localparam int IDX_W   = ROW_W + EW;
	localparam int TOT_W   = HEIGHT_W + EW;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int CNT_W   = FIFO_AW + 1;
	localparam int NWIN    = KERNEL_SIZE * KERNEL_SIZE;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             last;
	} res_entry_t;

	// ---------------- configuration registers ----------------
	logic [WIDTH_REG_W-1:0] width_q;
	logic [HEIGHT_W-1:0]    height_q;
	logic [ROWREG_W-1:0]    wrow_q [KERNEL_SIZE];
	logic                   cfg_wr;
	reg_idx_t               cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_REG_W'(RESET_WIDTH);
			height_q  <= HEIGHT_W'(RESET_HEIGHT);
			wrow_q[0] <= RESET_TOP;
			wrow_q[1] <= RESET_MID;
			wrow_q[2] <= RESET_BOT;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_WIDTH:  width_q   <= pwdata[WIDTH_REG_W-1:0];
				REG_HEIGHT: height_q  <= pwdata[HEIGHT_W-1:0];
				REG_TOP:    wrow_q[0] <= pwdata[ROWREG_W-1:0];
				REG_MID:    wrow_q[1] <= pwdata[ROWREG_W-1:0];
				REG_BOT:    wrow_q[2] <= pwdata[ROWREG_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (cfg_idx)
			REG_WIDTH:  prdata = APB_DW'(width_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			REG_TOP:    prdata = APB_DW'(wrow_q[0]);
			REG_MID:    prdata = APB_DW'(wrow_q[1]);
			REG_BOT:    prdata = APB_DW'(wrow_q[2]);
			default:    prdata = '0;
		endcase
	end

	// effective frame size: zero counts as one, width clamps to the line memory
	logic [EW-1:0]       w_eff;
	logic [HEIGHT_W-1:0] h_eff;

	always_comb begin
		if (width_q == '0) begin
			w_eff = EW'(1);
		end else if (EW'(width_q) > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(width_q);
		end
	end
	assign h_eff = (height_q == '0) ? HEIGHT_W'(1) : height_q;

	// ---------------- control state ----------------
	logic             clr_busy_q;
	logic [COL_W-1:0] clr_addr_q;
	logic             recalc_q;
	logic             push2_q;
	logic [CNT_W-1:0] outstanding_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [IDX_W-1:0] idx_q;
	logic [TOT_W-1:0] total_q;
	logic [COL_W-1:0] ocol_q;
	logic [ROW_W-1:0] orow_q;

	// ---------------- issue stage ----------------
	logic               in_acc;
	logic               frame_done;
	logic               push_go;
	logic [PIXEL_W-1:0] push_px;
	logic               emit0;
	logic               col_end;
	logic               ocol_end;
	logic               orow_end;
	logic               last0;
	logic               issue_emit;
	logic               out_pop;

	assign pixels.ready = !clr_busy_q && !recalc_q && !push2_q &&
	                      (outstanding_q < CNT_W'(FIFO_DEPTH));
	assign in_acc     = pixels.valid && pixels.ready;
	assign frame_done = idx_q >= IDX_W'(total_q);
	assign push_go    = push2_q ||
	                    (in_acc && ((pixels.kind == KIND_PIXEL) ? !frame_done : frame_done));
	assign push_px    = (!push2_q && pixels.kind == KIND_PIXEL) ? pixels.pixel : '0;
	assign emit0      = idx_q >= (IDX_W'(w_eff) + IDX_W'(1));
	assign col_end    = ((EW+1)'(col_q) + (EW+1)'(1)) >= (EW+1)'(w_eff);
	assign ocol_end   = ((EW+1)'(ocol_q) + (EW+1)'(1)) >= (EW+1)'(w_eff);
	assign orow_end   = ((ROW_W+1)'(orow_q) + (ROW_W+1)'(1)) >= (ROW_W+1)'(h_eff);
	assign last0      = orow_end && ocol_end;
	assign issue_emit = push_go && emit0;
	assign out_pop    = results.valid && results.ready;

	// clearing pass, interlocks and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q    <= 1'b1;
			clr_addr_q    <= '0;
			recalc_q      <= 1'b1;
			push2_q       <= 1'b0;
			outstanding_q <= '0;
			col_q         <= '0;
			row_q         <= '0;
			idx_q         <= '0;
			total_q       <= '0;
			ocol_q        <= '0;
			orow_q        <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + COL_W'(1);
				if (clr_addr_q == COL_W'(MAX_WIDTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end

			// a size change moves the linear position and the frame length
			recalc_q <= cfg_wr;
			if (recalc_q) begin
				total_q <= TOT_W'(h_eff) * TOT_W'(w_eff);
			end

			// second zero push of a drain that did not release a result
			push2_q <= in_acc && (pixels.kind == KIND_DRAIN) && frame_done && !emit0;

			if (issue_emit && !out_pop) begin
				outstanding_q <= outstanding_q + CNT_W'(1);
			end else if (!issue_emit && out_pop) begin
				outstanding_q <= outstanding_q - CNT_W'(1);
			end

			if (recalc_q) begin
				idx_q <= IDX_W'(row_q) * IDX_W'(w_eff) + IDX_W'(col_q);
			end else if (push_go) begin
				if (emit0 && last0) begin
					// frame complete: every position starts over
					col_q  <= '0;
					row_q  <= '0;
					idx_q  <= '0;
					ocol_q <= '0;
					orow_q <= '0;
				end else begin
					if (col_end) begin
						col_q <= '0;
						row_q <= row_q + ROW_W'(1);
						idx_q <= idx_q - IDX_W'(col_q) + IDX_W'(w_eff);
					end else begin
						col_q <= col_q + COL_W'(1);
						idx_q <= idx_q + IDX_W'(1);
					end
					if (emit0) begin
						if (ocol_end) begin
							ocol_q <= '0;
							orow_q <= orow_q + ROW_W'(1);
						end else begin
							ocol_q <= ocol_q + COL_W'(1);
						end
					end
				end
			end
		end
	end

	// ---------------- line memory: {row two above, row above} per column ----------------
	logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIXEL_W-1:0] mem_rd_s1;
	logic                 mem_we;
	logic [COL_W-1:0]     mem_wa;
	logic [2*PIXEL_W-1:0] mem_wd;

	logic                 push_s1;
	logic                 emit_s1;
	logic                 last_s1;
	logic                 fwd_s1;
	logic [COL_W-1:0]     col_s1;
	logic [PIXEL_W-1:0]   px_s1;
	logic [KERNEL_SIZE-1:0] rowok_s1;
	logic [KERNEL_SIZE-1:0] colok_s1;
	logic [PIXEL_W-1:0]   fwd_top_q;
	logic [PIXEL_W-1:0]   fwd_mid_q;
	logic [PIXEL_W-1:0]   top_s1v;
	logic [PIXEL_W-1:0]   mid_s1v;

	assign mem_we = clr_busy_q || push_s1;
	assign mem_wa = clr_busy_q ? clr_addr_q : col_s1;
	assign mem_wd = clr_busy_q ? '0 : {mid_s1v, px_s1};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[mem_wa] <= mem_wd;
		end
		if (push_go) begin
			mem_rd_s1 <= line_mem[col_q];
		end
	end

	// a push to the column written this cycle takes the written values
	assign top_s1v = fwd_s1 ? fwd_top_q : mem_rd_s1[2*PIXEL_W-1:PIXEL_W];
	assign mid_s1v = fwd_s1 ? fwd_mid_q : mem_rd_s1[PIXEL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_s1 <= 1'b0;
			emit_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
		end else begin
			push_s1 <= push_go;
			emit_s1 <= issue_emit;
			fwd_s1  <= push_go && push_s1 && (col_q == col_s1);
		end
	end

	// stage 1 payload; edge masks follow the output position
	always_ff @(posedge clk) begin
		col_s1      <= col_q;
		px_s1       <= push_px;
		last_s1     <= last0;
		rowok_s1[0] <= orow_q != '0;
		rowok_s1[1] <= 1'b1;
		rowok_s1[2] <= !orow_end;
		colok_s1[0] <= ocol_q != '0;
		colok_s1[1] <= 1'b1;
		colok_s1[2] <= !ocol_end;
		fwd_top_q   <= mid_s1v;
		fwd_mid_q   <= px_s1;
	end

	// ---------------- window and products ----------------
	logic [PIXEL_W-1:0]       window_q [NWIN];
	logic [PIXEL_W-1:0]       win_next [NWIN];
	logic signed [PROD_W-1:0] prod_c   [NWIN];
	logic signed [PROD_W-1:0] prod_s2  [NWIN];
	logic                     emit_s2;
	logic                     last_s2;

	always_comb begin
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			win_next[r*KERNEL_SIZE]     = window_q[r*KERNEL_SIZE + 1];
			win_next[r*KERNEL_SIZE + 1] = window_q[r*KERNEL_SIZE + 2];
		end
		win_next[2] = top_s1v;
		win_next[5] = mid_s1v;
		win_next[8] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NWIN; i++) begin
				window_q[i] <= '0;
			end
		end else if (push_s1) begin
			window_q <= win_next;
		end
	end

	// nine taps; positions outside the frame contribute nothing
	always_comb begin
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			for (int c = 0; c < KERNEL_SIZE; c++) begin
				if (rowok_s1[r] && colok_s1[c]) begin
					prod_c[r*KERNEL_SIZE + c] = weight_at(wrow_q[r], c) *
						$signed({1'b0, win_next[r*KERNEL_SIZE + c]});
				end else begin
					prod_c[r*KERNEL_SIZE + c] = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
		end else begin
			emit_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_c;
		last_s2 <= last_s1;
	end

	// ---------------- adder tree: row sums, then total ----------------
	logic signed [SUM_W-1:0] rsum_c  [KERNEL_SIZE];
	logic signed [SUM_W-1:0] rsum_s3 [KERNEL_SIZE];
	logic signed [SUM_W-1:0] total_c;
	logic                    emit_s3;
	logic                    last_s3;

	always_comb begin
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			rsum_c[r] = SUM_W'(prod_s2[r*KERNEL_SIZE]) +
			            SUM_W'(prod_s2[r*KERNEL_SIZE + 1]) +
			            SUM_W'(prod_s2[r*KERNEL_SIZE + 2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s3 <= 1'b0;
		end else begin
			emit_s3 <= emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		rsum_s3 <= rsum_c;
		last_s3 <= last_s2;
	end

	assign total_c = rsum_s3[0] + rsum_s3[1] + rsum_s3[2];

	// ---------------- result queue; credits keep it from overflowing ----------------
	res_entry_t         fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0]   fifo_cnt_q;

	always_ff @(posedge clk) begin
		if (emit_s3) begin
			fifo_q[wr_ptr_q] <= '{sum: total_c, last: last_s3};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (emit_s3) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (out_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (emit_s3 && !out_pop) begin
				fifo_cnt_q <= fifo_cnt_q + CNT_W'(1);
			end else if (!emit_s3 && out_pop) begin
				fifo_cnt_q <= fifo_cnt_q - CNT_W'(1);
			end
		end
	end

	assign results.valid      = fifo_cnt_q != '0;
	assign results.sum_value  = fifo_q[rd_ptr_q].sum;
	assign results.frame_last = fifo_q[rd_ptr_q].last;

endmodule

// ===== hdl/wf_checker.sv =====
// wf_checker: port-level assertions for window_filter_3x3, attached with bind.
// Depends on wf_pkg and the top level's port list.

module wf_checker import wf_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic              pready,
	input logic [APB_AW-1:0] paddr,
	input logic [APB_DW-1:0] pwdata,
	input logic [APB_DW-1:0] prdata,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [SUM_W-1:0]  out_sum,
	input logic              out_last
);

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sum) && $stable(out_last))
		else $error("result changed while stalled");

	// line memory is being cleared right after reset, so no request is taken
	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_ready)
		else $error("request taken during clearing pass");

	// frame position is recomputed the cycle after a register write
	a_cfg_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !in_ready)
		else $error("request taken during size recompute");

	// height register reads back what was written
	a_height_readback: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && (paddr[APB_AW-1:3] == REG_HEIGHT) |=>
		(paddr != $past(paddr)) || (prdata[HEIGHT_W-1:0] == $past(pwdata[HEIGHT_W-1:0])))
		else $error("height readback mismatch");

endmodule

bind window_filter_3x3 wf_checker u_wf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.pready    (pready),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata),
	.in_ready  (pixels.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_sum   (results.sum_value),
	.out_last  (results.frame_last)
);

// ===== test/window_filter_3x3_test.sv =====
// window_filter_3x3_test: self-checking bench for the 3x3 window filter; keeps its own
// copy of the line stores, window and raster counters and predicts every result.
// Depends on wf_pkg, wf_pixel_if, wf_result_if and window_filter_3x3.

module window_filter_3x3_test;
	timeunit 1ns;
	timeprecision 1ps;
	import wf_pkg::*;

	localparam int LINE_DEPTH    = MAX_WIDTH_DEF;
	localparam int QUIET_LIMIT   = 4096;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 1650;
	localparam int TAIL_CYCLES   = 16;
	localparam int REPORT_CAP    = 40;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum_value;
		logic                    frame_last;
	} filter_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	wf_pixel_if  pixels();
	wf_result_if results();

	window_filter_3x3 uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pixels  (pixels),
		.results (results)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow copy of the registers
	logic [WIDTH_REG_W-1:0] width_reg;
	logic [HEIGHT_W-1:0]    height_reg;
	logic [ROWREG_W-1:0]    row_reg [KERNEL_SIZE];

	// shadow copy of the filter state
	logic [PIXEL_W-1:0] row_above     [LINE_DEPTH];
	logic [PIXEL_W-1:0] row_two_above [LINE_DEPTH];
	logic [PIXEL_W-1:0] window        [KERNEL_SIZE*KERNEL_SIZE];
	int unsigned        take_col, take_row, give_col, give_row;

	filter_result_t expected_sums [$];
	bit             frame_done;
	bit             no_gaps;
	bit             offering;
	int unsigned    mismatches;
	int unsigned    results_checked;
	int unsigned    frames_closed;
	int unsigned    items_taken;
	int unsigned    quiet_cycles;
	int unsigned    stall_left;

	function automatic int unsigned cols_in_use();
		if (width_reg == 0)
			return 1;
		if (width_reg > LINE_DEPTH)
			return LINE_DEPTH;
		return width_reg;
	endfunction

	function automatic int unsigned rows_in_use();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	function automatic int unsigned step_sat(input int unsigned v);
		return (v == 32'hFFFF_FFFF) ? v : v + 1;
	endfunction

	// shift one pixel through line stores and window; returns 1 when a sum comes out
	function automatic bit push_through_window(input logic [PIXEL_W-1:0] px,
			output filter_result_t res);
		int unsigned           w, h, col;
		int                    r, c;
		longint unsigned       pos;
		bit                    emit, last;
		logic [PIXEL_W-1:0]    above, two_above;
		logic signed [WEIGHT_W-1:0] wt;
		longint                acc;

		w = cols_in_use();
		h = rows_in_use();
		pos = longint'(take_row) * w + take_col;
		emit = pos >= w + 1;
		col = (take_col < LINE_DEPTH) ? take_col : LINE_DEPTH - 1;
		two_above = row_two_above[col];
		above = row_above[col];
		row_two_above[col] = above;
		row_above[col] = px;
		for (r = 0; r < KERNEL_SIZE; r++) begin
			window[r*3]     = window[r*3 + 1];
			window[r*3 + 1] = window[r*3 + 2];
		end
		window[2] = two_above;
		window[5] = above;
		window[8] = px;

		if (longint'(take_col) + 1 >= w) begin
			take_col = 0;
			take_row = step_sat(take_row);
		end else begin
			take_col++;
		end

		res = '0;
		if (!emit)
			return 1'b0;

		// zero padding: skip taps that fall outside the frame
		acc = 0;
		for (r = 0; r < KERNEL_SIZE; r++) begin
			if (r == 0 && give_row < 1)
				continue;
			if (r == 2 && longint'(give_row) + 1 >= h)
				continue;
			for (c = 0; c < KERNEL_SIZE; c++) begin
				if (c == 0 && give_col < 1)
					continue;
				if (c == 2 && longint'(give_col) + 1 >= w)
					continue;
				wt = row_reg[r][c*WEIGHT_W +: WEIGHT_W];
				acc += longint'(wt) * longint'(window[r*3 + c]);
			end
		end
		last = (longint'(give_row) + 1 >= h) && (longint'(give_col) + 1 >= w);
		res.sum_value = acc[SUM_W-1:0];
		res.frame_last = last;

		if (last) begin
			take_col = 0;
			take_row = 0;
			give_col = 0;
			give_row = 0;
			frame_done = 1'b1;
		end else if (longint'(give_col) + 1 >= w) begin
			give_col = 0;
			give_row = step_sat(give_row);
		end else begin
			give_col++;
		end
		return 1'b1;
	endfunction

	// what one accepted request does: taken unless ignored, emits if a sum comes out
	function automatic void convolve_request(input logic kind, input logic [PIXEL_W-1:0] px,
			output bit taken, output bit emits, output filter_result_t res);
		int unsigned     w;
		longint unsigned total, pos;

		w = cols_in_use();
		total = longint'(rows_in_use()) * w;
		pos = longint'(take_row) * w + take_col;
		taken = 1'b0;
		emits = 1'b0;
		res = '0;
		if (kind == KIND_PIXEL) begin
			if (pos >= total)
				return;
			taken = 1'b1;
			emits = push_through_window(px, res);
			return;
		end
		if (pos < total)
			return;
		// a drain pushes zeros until one sum comes out
		taken = 1'b1;
		emits = push_through_window('0, res);
		if (!emits)
			emits = push_through_window('0, res);
	endfunction

	function automatic logic [PIXEL_W-1:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIXEL_W'($urandom);
		endcase
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return '0;
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	function automatic logic [ROWREG_W-1:0] pick_row();
		return {pick_weight(), pick_weight(), pick_weight()};
	endfunction

	task automatic hold_valid_low();
		if (offering) begin
			pixels.valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	// offer one request, wait for it to be taken, then record its expected sum
	task automatic offer_request(input logic kind, input logic [PIXEL_W-1:0] px);
		bit             taken, emits;
		filter_result_t res;

		if (!no_gaps && $urandom_range(0, 5) == 0) begin
			hold_valid_low();
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		pixels.valid <= 1'b1;
		pixels.kind  <= kind;
		pixels.pixel <= px;
		offering = 1'b1;
		do @(posedge clk); while (!pixels.ready);
		convolve_request(kind, px, taken, emits, res);
		if (taken)
			items_taken++;
		if (emits)
			expected_sums.push_back(res);
	endtask

	task automatic wait_for_results();
		hold_valid_low();
		while (expected_sums.size() != 0)
			@(posedge clk);
	endtask

	// APB write: setup then access; psel is held across back-to-back writes
	task automatic write_register(input reg_idx_t idx, input logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 3'b000});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_WIDTH:  width_reg  = value[WIDTH_REG_W-1:0];
			REG_HEIGHT: height_reg = value[HEIGHT_W-1:0];
			REG_TOP:    row_reg[0] = value[ROWREG_W-1:0];
			REG_MID:    row_reg[1] = value[ROWREG_W-1:0];
			REG_BOT:    row_reg[2] = value[ROWREG_W-1:0];
			default: ;
		endcase
	endtask

	// registers change only once the block has gone quiet
	task automatic load_settings(input int unsigned w, input int unsigned h,
			input logic [ROWREG_W-1:0] top, input logic [ROWREG_W-1:0] mid,
			input logic [ROWREG_W-1:0] bot);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_register(REG_WIDTH, APB_DW'(w));
		write_register(REG_HEIGHT, APB_DW'(h));
		write_register(REG_TOP, APB_DW'(top));
		write_register(REG_MID, APB_DW'(mid));
		write_register(REG_BOT, APB_DW'(bot));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// drain until the last sum of the frame; noise mixes in surplus pixels
	task automatic close_frame(input int unsigned noise_pct);
		while (!frame_done) begin
			if ($urandom_range(0, 99) < noise_pct)
				offer_request(KIND_PIXEL, pick_pixel());
			else
				offer_request(KIND_DRAIN, PIXEL_W'($urandom));
		end
		frame_done = 1'b0;
		frames_closed++;
	endtask

	task automatic run_frame(input int unsigned noise_pct);
		int unsigned count, k;

		count = cols_in_use() * rows_in_use();
		for (k = 0; k < count; k++) begin
			// stray drains inside the frame are ignored
			if ($urandom_range(0, 99) < noise_pct)
				offer_request(KIND_DRAIN, PIXEL_W'($urandom));
			if (!no_gaps && $urandom_range(0, 249) == 0)
				wait_for_results();
			offer_request(KIND_PIXEL, pick_pixel());
		end
		close_frame(noise_pct);
	endtask

	// full-scale sums on 3x3 frames, plus ignored drains and a surplus pixel
	task automatic test_extreme_sums();
		int k;

		load_settings(3, 3, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
		for (k = 0; k < 9; k++) begin
			offer_request(KIND_PIXEL, 8'hFF);
			if (k == 4)
				offer_request(KIND_DRAIN, 8'h00);
		end
		offer_request(KIND_PIXEL, 8'h00);
		close_frame(0);

		// a drain right after the frame's last sum starts nothing
		offer_request(KIND_DRAIN, 8'hFF);
		load_settings(3, 3, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
		for (k = 0; k < 9; k++)
			offer_request(KIND_PIXEL, 8'hFF);
		close_frame(0);
	endtask

	task automatic test_random_frames();
		int unsigned start, w, h;

		start = items_taken;
		while (items_taken - start < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					w = $urandom_range(0, 3);
					h = $urandom_range(0, 3);
				end
				1: begin
					w = $urandom_range(17, 80);
					h = $urandom_range(1, 3);
				end
				2: begin
					w = $urandom_range(1, 3);
					h = $urandom_range(10, 60);
				end
				default: begin
					w = $urandom_range(1, 12);
					h = $urandom_range(1, 8);
				end
			endcase
			load_settings(w, h, pick_row(), pick_row(), pick_row());
			no_gaps = ($urandom_range(0, 4) == 0);
			run_frame($urandom_range(0, 8));
		end
	endtask

	// width register above the line length clamps to the full line
	task automatic test_widest_rows();
		no_gaps = 1'b0;
		load_settings(2047, 1, pick_row(), pick_row(), pick_row());
		run_frame(2);
	endtask

	// start of a maximum-height frame, back to back with no idling
	task automatic test_tallest_frame();
		int k;

		no_gaps = 1'b1;
		load_settings(2, 65535, pick_row(), pick_row(), pick_row());
		for (k = 0; k < 300; k++)
			offer_request(KIND_PIXEL, pick_pixel());
	endtask

	// result side: random stall bursts unless idling is off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
			stall_left <= 0;
		end else if (no_gaps) begin
			results.ready <= 1'b1;
		end else if (stall_left != 0) begin
			results.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			results.ready <= 1'b0;
			stall_left <= $urandom_range(0, 9);
		end else begin
			results.ready <= 1'b1;
		end
	end

	// compare every result with the oldest expected sum
	always @(posedge clk) begin
		filter_result_t want;
		if (arst_n === 1'b1 && results.valid && results.ready) begin
			if (expected_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$display("%0t: unexpected result sum %0d frame_last %0b", $time,
						results.sum_value, results.frame_last);
			end else begin
				want = expected_sums.pop_front();
				results_checked++;
				if (results.sum_value !== want.sum_value) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$display("%0t: sum_value expected %0d got %0d", $time,
							want.sum_value, results.sum_value);
				end
				if (results.frame_last !== want.frame_last) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$display("%0t: frame_last expected %0b got %0b", $time,
							want.frame_last, results.frame_last);
				end
			end
		end
	end

	// stop a hung run: nothing moved on any port for too long
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (pixels.valid && pixels.ready) ||
				(results.valid && results.ready) || (psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: nothing accepted for %0d cycles", $time, QUIET_LIMIT);
			$display("window_filter_3x3_test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		pixels.valid <= 1'b0;
		pixels.kind  <= KIND_PIXEL;
		pixels.pixel <= '0;

		// model starts from the reset defaults
		width_reg  = WIDTH_REG_W'(RESET_WIDTH);
		height_reg = HEIGHT_W'(RESET_HEIGHT);
		row_reg[0] = RESET_TOP;
		row_reg[1] = RESET_MID;
		row_reg[2] = RESET_BOT;
		foreach (row_above[i]) begin
			row_above[i] = '0;
			row_two_above[i] = '0;
		end
		foreach (window[i])
			window[i] = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// line memory clearing pass
		do @(posedge clk); while (!pixels.ready);

		test_extreme_sums();
		test_random_frames();
		test_widest_rows();
		test_tallest_frame();

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d closed frames and %0d consumed requests", frames_closed,
			items_taken);
		$display("%0d results checked, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("window_filter_3x3_test passed");
		else
			$display("window_filter_3x3_test failed");
		$finish;
	end

endmodule
